FILE: hdl/assert_macros.svh
// Assertion macros for the RTL top level of the dispatcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, idle while reset is active.
`define PTCD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle.
`define PTCD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: hdl/ptcd_pkg.sv
// Types, codes and constants of the priority task capacity dispatcher.
`timescale 1ns / 1ps

package ptcd_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int TAG_W           = 8;
	localparam int PRIO_W          = 4;
	localparam int DEM_W           = 16;
	localparam int CAP_W           = 16;
	localparam int CNT_OUT_W       = 5;

	localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
	localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;
	localparam logic [CAP_W-1:0]  CAP_MAX  = 16'hFFFF;
	localparam logic [CAP_W-1:0]  INIT_CAP_RST = 16'd10;

	typedef struct packed {
		logic [DEM_W-1:0]  demand;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_ADD      = 2'd1,
		CMD_DISPATCH = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_SERVED    = 3'd3,
		STAT_NONE      = 3'd4,
		STAT_CAP_ADDED = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_INS_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_END,
		S_DSP_EVAL,
		S_DSP_CHK,
		S_DSP_TAKE
	} state_t;

	// Clamp a requested priority into the legal range.
	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [7:0] p);
		logic [PRIO_W-1:0] r;
		if (p < 8'(PRIO_MIN)) begin
			r = PRIO_MIN;
		end else if (p > 8'(PRIO_MAX)) begin
			r = PRIO_MAX;
		end else begin
			r = p[PRIO_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/ptcd_ram.sv
// Task queue storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ptcd_ram
	import ptcd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(QUEUE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/priority_task_capacity_dispatcher_unit.sv
// Top level of the priority task capacity dispatcher: sequencer, budget and output register.
//
// Input stream (s_*): one request per handshake; s_tuser carries the command
// (insert, add capacity, dispatch), s_tdata the task tag, priority and demand.
// Output stream (m_*): result items; m_tuser is the status, m_tlast marks the
// final result of a request. Insert and add-capacity give one result each,
// dispatch gives one result per served task (up to 16) or a single
// "none served" result. An unused command gives no result.
// The APB port holds initial_capacity at address 0; writing it also reloads
// the running budget.
// Sequencing: requests are taken only in the idle state. Insert reads every
// queued task through the single read port of the task memory to find a
// duplicate and its place, then moves each entry behind that place one step
// toward the tail and writes the new task. Dispatch reads the head, checks
// that it fits and takes it, until the queue empties, the budget is zero,
// 16 tasks are served or the head does not fit, one entry at a time.
// Results sit in an output register; a new request is taken while the last
// result still waits, and the sequencer holds when it must load a result
// while the receiver stalls. Reset empties the queue and loads a budget of 10.
// The task memory needs no clearing pass: only entries below the count are read.
`timescale 1ns / 1ps

module priority_task_capacity_dispatcher_unit
	import ptcd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // task_tag[7:0], task_priority[15:8], task_demand[31:16]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // served_tag[7:0], served_priority[11:8],
	                              // served_demand[27:12], capacity_left[43:28],
	                              // queued_count[48:44], zero fill
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [IW-1:0] HEAD_LAST = IW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] NRES_MAX = NW'(MAX_RESULTS);

	state_t state_q, state_d;

	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    head_q;
	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] init_q;
	logic [CW-1:0]    idx_q;
	logic [NW-1:0]    nres_q;
	logic             dup_q;
	logic             found_q;
	logic             pend_q;
	logic             m_tvalid_q;

	entry_t           new_q;
	logic [CW-1:0]    pos_q;
	entry_t           pend_entry_q;
	logic [CAP_W-1:0] pend_cap_q;
	logic [CNT_OUT_W-1:0] pend_cnt_q;

	status_t          out_status_q;
	entry_t           out_entry_q;
	logic [CAP_W-1:0] out_cap_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;
	logic             out_last_q;

	logic    ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t  ram_wdata, ram_rdata;

	logic    accept, out_free, cfg_we;
	logic    em_req, em_load;
	status_t em_status;
	entry_t  em_entry;
	logic [CAP_W-1:0] em_cap;
	logic [CNT_OUT_W-1:0] em_cnt;
	logic    em_last;
	logic    start_ins, start_dsp, cmp_step, idx_inc, idx_dec, idx_load;
	logic    cnt_inc, take, cap_inc;

	logic [CW+CNT_OUT_W-1:0] cnt_ext, cnt_dec_ext;
	logic [CW-1:0]    cnt_dec;
	logic [CNT_OUT_W-1:0] cnt5, cnt_dec5;
	logic [CAP_W-1:0] cap_sub, cap_inc_v;
	logic             fit, dsp_cont, before_e, match_e;
	entry_t           zero_entry;

	// Map a queue position onto a memory address of the ring.
	function automatic logic [IW-1:0] phys(input logic [CW-1:0] idx,
	                                        input logic [IW-1:0] head);
		logic [CW:0] s;
		s = (CW + 1)'(head) + (CW + 1)'(idx);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[IW-1:0];
	endfunction

	ptcd_ram #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_we   = psel && penable && pwrite && !paddr[2];
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {16'd0, init_q};

	assign zero_entry  = '0;
	assign cnt_ext     = {{CNT_OUT_W{1'b0}}, cnt_q};
	assign cnt5        = cnt_ext[CNT_OUT_W-1:0];
	assign cnt_dec     = cnt_q - CW'(1);
	assign cnt_dec_ext = {{CNT_OUT_W{1'b0}}, cnt_dec};
	assign cnt_dec5    = cnt_dec_ext[CNT_OUT_W-1:0];
	assign cap_sub     = cap_q - ram_rdata.demand;
	assign cap_inc_v   = (cap_q == CAP_MAX) ? cap_q : cap_q + CAP_W'(1);
	assign fit         = (ram_rdata.demand <= cap_q);
	assign dsp_cont    = (cnt_q != '0) && (cap_q != '0) && (nres_q != NRES_MAX);
	assign before_e    = (new_q.prio > ram_rdata.prio) ||
	                     ((new_q.prio == ram_rdata.prio) && (new_q.demand < ram_rdata.demand));
	assign match_e     = (new_q.prio == ram_rdata.prio) && (new_q.demand == ram_rdata.demand);
	assign em_load     = em_req && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = phys(idx_q, head_q);
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = phys(idx_q, head_q);
		em_req    = 1'b0;
		em_status = STAT_NONE;
		em_entry  = zero_entry;
		em_cap    = cap_q;
		em_cnt    = cnt5;
		em_last   = 1'b1;
		start_ins = 1'b0;
		start_dsp = 1'b0;
		cmp_step  = 1'b0;
		idx_inc   = 1'b0;
		idx_dec   = 1'b0;
		idx_load  = 1'b0;
		cnt_inc   = 1'b0;
		take      = 1'b0;
		cap_inc   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(s_tuser))
						CMD_INSERT: begin
							start_ins = 1'b1;
							state_d   = S_SCAN_RD;
						end
						CMD_ADD: begin
							state_d = S_ADD;
						end
						CMD_DISPATCH: begin
							start_dsp = 1'b1;
							state_d   = S_DSP_EVAL;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ADD: begin
				em_req    = 1'b1;
				em_status = STAT_CAP_ADDED;
				em_cap    = cap_inc_v;
				if (out_free) begin
					cap_inc = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				if (idx_q == cnt_q) begin
					state_d = S_INS_DECIDE;
				end else begin
					ram_re  = 1'b1;
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				cmp_step = 1'b1;
				idx_inc  = 1'b1;
				state_d  = S_SCAN_RD;
			end
			S_INS_DECIDE: begin
				if (dup_q || (cnt_q == DEPTH_C)) begin
					em_req    = 1'b1;
					em_status = dup_q ? STAT_DUPLICATE : STAT_FULL;
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					idx_load = 1'b1;
					state_d  = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (idx_q == pos_q) begin
					ram_we    = 1'b1;
					ram_wdata = new_q;
					cnt_inc   = 1'b1;
					state_d   = S_INS_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = phys(idx_q - CW'(1), head_q);
					state_d   = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				// move the entry one place toward the tail
				ram_we  = 1'b1;
				idx_dec = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_INS_END: begin
				em_req    = 1'b1;
				em_status = STAT_INSERTED;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DSP_EVAL: begin
				if (dsp_cont) begin
					ram_re    = 1'b1;
					ram_raddr = head_q;
					state_d   = S_DSP_CHK;
				end else begin
					em_req = 1'b1;
					if (pend_q) begin
						em_status = STAT_SERVED;
						em_entry  = pend_entry_q;
						em_cap    = pend_cap_q;
						em_cnt    = pend_cnt_q;
					end
					if (out_free) begin
						state_d = S_IDLE;
					end
				end
			end
			S_DSP_CHK: begin
				// the held result is marked last here only if the next head fails to fit
				if (pend_q) begin
					em_req    = 1'b1;
					em_status = STAT_SERVED;
					em_entry  = pend_entry_q;
					em_cap    = pend_cap_q;
					em_cnt    = pend_cnt_q;
					em_last   = !fit;
				end else if (!fit) begin
					em_req = 1'b1;
				end
				if (!em_req || out_free) begin
					state_d = fit ? S_DSP_TAKE : S_IDLE;
				end
			end
			S_DSP_TAKE: begin
				take    = 1'b1;
				state_d = S_DSP_EVAL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			head_q     <= '0;
			cap_q      <= INIT_CAP_RST;
			init_q     <= INIT_CAP_RST;
			idx_q      <= '0;
			nres_q     <= '0;
			dup_q      <= 1'b0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_q <= pwdata[CAP_W-1:0];
				cap_q  <= pwdata[CAP_W-1:0];
			end
			// drop any held result as soon as a new request arrives
			if (accept) begin
				pend_q <= 1'b0;
			end
			if (start_ins) begin
				idx_q   <= '0;
				dup_q   <= 1'b0;
				found_q <= 1'b0;
			end
			if (start_dsp) begin
				nres_q <= '0;
			end
			if (cmp_step) begin
				if (match_e) begin
					dup_q <= 1'b1;
				end
				if (before_e) begin
					found_q <= 1'b1;
				end
			end
			if (idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (idx_load) begin
				idx_q <= cnt_q;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cap_inc) begin
				cap_q <= cap_inc_v;
			end
			if (take) begin
				cap_q  <= cap_sub;
				cnt_q  <= cnt_dec;
				head_q <= (head_q == HEAD_LAST) ? '0 : head_q + IW'(1);
				nres_q <= nres_q + NW'(1);
				pend_q <= 1'b1;
			end
			if (em_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.tag    <= s_tdata[7:0];
			new_q.prio   <= clamp_prio(s_tdata[15:8]);
			new_q.demand <= s_tdata[31:16];
		end
		if (start_ins) begin
			pos_q <= cnt_q;
		end
		if (cmp_step && before_e && !found_q) begin
			pos_q <= idx_q;
		end
		if (take) begin
			pend_entry_q <= ram_rdata;
			pend_cap_q   <= cap_sub;
			pend_cnt_q   <= cnt_dec5;
		end
		if (em_load) begin
			out_status_q <= em_status;
			out_entry_q  <= em_entry;
			out_cap_q    <= em_cap;
			out_cnt_q    <= em_cnt;
			out_last_q   <= em_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_cap_q, out_entry_q.demand,
	                   out_entry_q.prio, out_entry_q.tag};

	`PTCD_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= DEPTH_C, "queue count beyond depth")
	`PTCD_ASSERT(a_pend_in_dispatch, clk, arst_n,
		!pend_q || (state_q == S_DSP_EVAL) || (state_q == S_DSP_CHK) ||
		(state_q == S_DSP_TAKE) || (state_q == S_IDLE),
		"pending result outside dispatch")
	`PTCD_ASSERT_NEXT(a_take_pops, clk, arst_n, state_q == S_DSP_TAKE,
		cnt_q == $past(cnt_q) - CW'(1), "dispatch pop did not shrink the queue")
	`PTCD_ASSERT(a_served_prio, clk, arst_n,
		!(m_tvalid_q && (out_status_q == STAT_SERVED)) ||
		((out_entry_q.prio >= PRIO_MIN) && (out_entry_q.prio <= PRIO_MAX)),
		"served task carries an unclamped priority")

endmodule

FILE: tb/sv/ptcd_result_checker.sv
// Result checker for the dispatcher: tracks the task queue and budget, predicts and compares results.
`timescale 1ns / 1ps

module ptcd_result_checker
	import ptcd_pkg::*;
#(
	parameter int         QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter logic [2:0] CAP_REG_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // task_tag[7:0], task_priority[15:8], task_demand[31:16]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // served_tag[7:0], served_priority[11:8],
	                              // served_demand[27:12], capacity_left[43:28],
	                              // queued_count[48:44], zero fill
	input  logic [2:0]  m_tuser,  // status[2:0]
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          results_due,
	output int          results_checked,
	output int          served_count,
	output int          dup_count,
	output int          full_count,
	output int          none_count
);

	typedef struct packed {
		status_t              status;
		logic [TAG_W-1:0]     tag;
		logic [PRIO_W-1:0]    prio;
		logic [DEM_W-1:0]     demand;
		logic [CAP_W-1:0]     budget;
		logic [CNT_OUT_W-1:0] queued;
		logic                 last;
	} result_t;

	localparam entry_t NO_TASK = '0;

	result_t          expected_results[$];
	entry_t           task_list[QUEUE_DEPTH];
	int               task_count;
	logic [CAP_W-1:0] budget;
	logic [CAP_W-1:0] init_budget;
	int               fails;
	int               checked;
	int               n_served;
	int               n_dup;
	int               n_full;
	int               n_none;

	assign mismatch_count  = fails;
	assign results_checked = checked;
	assign served_count    = n_served;
	assign dup_count       = n_dup;
	assign full_count      = n_full;
	assign none_count      = n_none;

	function automatic string result_text(result_t r);
		return $sformatf("status=%0d tag=%02h prio=%0d demand=%04h budget=%04h queued=%0d last=%0b",
			r.status, r.tag, r.prio, r.demand, r.budget, r.queued, r.last);
	endfunction

	function automatic void push_result(status_t st, entry_t t, logic last);
		result_t r;
		r.status = st;
		r.tag    = t.tag;
		r.prio   = t.prio;
		r.demand = t.demand;
		r.budget = budget;
		r.queued = task_count[CNT_OUT_W-1:0];
		r.last   = last;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_insert(logic [7:0] tag, logic [7:0] req_prio,
		logic [15:0] demand);
		entry_t  t;
		status_t st;
		int      pos;
		int      i;
		t.tag    = tag;
		t.demand = demand;
		if (req_prio < {4'd0, PRIO_MIN}) begin
			t.prio = PRIO_MIN;
		end else if (req_prio > {4'd0, PRIO_MAX}) begin
			t.prio = PRIO_MAX;
		end else begin
			t.prio = req_prio[PRIO_W-1:0];
		end
		st = STAT_INSERTED;
		// duplicate check takes precedence over the full check
		for (i = 0; i < task_count; i++) begin
			if (task_list[i].prio == t.prio && task_list[i].demand == t.demand) begin
				st = STAT_DUPLICATE;
			end
		end
		if (st == STAT_INSERTED && task_count >= QUEUE_DEPTH) begin
			st = STAT_FULL;
		end
		if (st == STAT_INSERTED) begin
			// find the first entry the new task outranks
			pos = task_count;
			for (i = task_count - 1; i >= 0; i--) begin
				if (t.prio > task_list[i].prio ||
					(t.prio == task_list[i].prio && t.demand < task_list[i].demand)) begin
					pos = i;
				end
			end
			for (i = task_count; i > pos; i--) begin
				task_list[i] = task_list[i-1];
			end
			task_list[pos] = t;
			task_count++;
		end
		push_result(st, NO_TASK, 1'b1);
	endfunction

	function automatic void predict_dispatch();
		entry_t head;
		int     served;
		int     i;
		logic   last_one;
		served = 0;
		while (served < MAX_RESULTS && task_count > 0 && budget != '0 &&
			task_list[0].demand <= budget) begin
			head   = task_list[0];
			budget = budget - head.demand;
			for (i = 1; i < task_count; i++) begin
				task_list[i-1] = task_list[i];
			end
			task_count--;
			served++;
			last_one = served >= MAX_RESULTS || task_count == 0 || budget == '0 ||
				task_list[0].demand > budget;
			push_result(STAT_SERVED, head, last_one);
		end
		if (served == 0) begin
			push_result(STAT_NONE, NO_TASK, 1'b1);
		end
	endfunction

	function automatic void predict_add();
		if (budget != CAP_MAX) begin
			budget = budget + 1'b1;
		end
		push_result(STAT_CAP_ADDED, NO_TASK, 1'b1);
	endfunction

	function automatic void check_result();
		result_t want;
		result_t got;
		got.status = status_t'(m_tuser);
		got.tag    = m_tdata[7:0];
		got.prio   = m_tdata[11:8];
		got.demand = m_tdata[27:12];
		got.budget = m_tdata[43:28];
		got.queued = m_tdata[48:44];
		got.last   = m_tlast;
		if (expected_results.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("%0t: result with nothing pending: %s", $realtime, result_text(got));
			end
		end else begin
			want = expected_results.pop_front();
			checked++;
			case (want.status)
				STAT_SERVED:    n_served++;
				STAT_DUPLICATE: n_dup++;
				STAT_FULL:      n_full++;
				STAT_NONE:      n_none++;
				default: ;
			endcase
			if (got.status != want.status || got.tag != want.tag || got.prio != want.prio ||
				got.demand != want.demand || got.budget != want.budget ||
				got.queued != want.queued || got.last != want.last ||
				m_tdata[55:49] != '0) begin
				fails++;
				if (fails <= 10) begin
					$display("%0t: result mismatch, fill=%02h", $realtime, m_tdata[55:49]);
					$display("  expected %s", result_text(want));
					$display("  actual   %s", result_text(got));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			task_count  = 0;
			init_budget = INIT_CAP_RST;
			budget      = INIT_CAP_RST;
			fails       = 0;
			checked     = 0;
			n_served    = 0;
			n_dup       = 0;
			n_full      = 0;
			n_none      = 0;
			results_due <= 0;
		end else begin
			if (psel && penable && pready && paddr == CAP_REG_ADDR) begin
				if (pwrite) begin
					// a write also reloads the running budget
					init_budget = pwdata[CAP_W-1:0];
					budget      = pwdata[CAP_W-1:0];
				end else if (prdata != {16'd0, init_budget}) begin
					fails++;
					if (fails <= 10) begin
						$display("%0t: register read mismatch: expected %08h actual %08h",
							$realtime, {16'd0, init_budget}, prdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_INSERT:   predict_insert(s_tdata[7:0], s_tdata[15:8], s_tdata[31:16]);
					CMD_ADD:      predict_add();
					CMD_DISPATCH: predict_dispatch();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				check_result();
			end
			results_due <= expected_results.size();
		end
	end

endmodule

FILE: tb/sv/priority_task_capacity_dispatcher_unit_tb.sv
// Testbench top of the dispatcher: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module priority_task_capacity_dispatcher_unit_tb;
	import ptcd_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam logic [2:0] INIT_CAP_ADDR = 3'd0;
	localparam int         DRAIN_CYCLES  = 120;
	localparam int         STALL_LIMIT   = 4000;
	localparam int         PHASE_ITEMS   = 113;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // task_tag[7:0], task_priority[15:8], task_demand[31:16]
	logic [1:0]  s_tuser  = '0;  // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // served_tag[7:0], served_priority[11:8],
	                             // served_demand[27:12], capacity_left[43:28],
	                             // queued_count[48:44], zero fill
	logic [2:0]  m_tuser;        // status[2:0]
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int results_due;
	int results_checked;
	int served_count;
	int dup_count;
	int full_count;
	int none_count;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles       = 0;
	int requests_sent      = 0;
	int ignored_sent       = 0;
	int reg_writes         = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	priority_task_capacity_dispatcher_unit DUT (.*);

	ptcd_result_checker #(
		.CAP_REG_ADDR(INIT_CAP_ADDR)
	) u_result_checker (.*);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// end the run when no handshake of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("No handshake for %0d cycles, %0d results outstanding",
					STALL_LIMIT, results_due);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [7:0] tag,
		input logic [7:0] prio, input logic [15:0] demand);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {demand, prio, tag};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (cmd == CMD_UNUSED) begin
			ignored_sent++;
		end else begin
			requests_sent++;
		end
	endtask

	task automatic send_random_request();
		logic [1:0]  cmd;
		logic [7:0]  prio;
		logic [15:0] demand;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			cmd = CMD_INSERT;
		end else if (pick < 70) begin
			cmd = CMD_ADD;
		end else if (pick < 94) begin
			cmd = CMD_DISPATCH;
		end else begin
			cmd = CMD_UNUSED;
		end
		// narrow priorities and small demands make duplicates and serving likely
		pick = $urandom_range(99);
		prio = (pick < 70) ? 8'($urandom_range(11)) : 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 55) begin
			demand = 16'($urandom_range(12));
		end else if (pick < 85) begin
			demand = 16'($urandom_range(300));
		end else begin
			demand = 16'($urandom_range(65535));
		end
		send_request(cmd, 8'($urandom_range(255)), prio, demand);
	endtask

	// drop valid, wait for every pending result, then let an unanswered request finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= INIT_CAP_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_capacity(input logic [15:0] value);
		wait_idle();
		apb_access(1'b1, {16'($urandom_range(65535)), value});
		apb_access(1'b0, '0);
		reg_writes++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_DISPATCH, 8'h00, 8'h00, 16'h0000);  // empty queue
		send_request(CMD_INSERT,   8'h00, 8'h00, 16'h0000);  // priority clamps up
		send_request(CMD_INSERT,   8'hFF, 8'hFF, 16'hFFFF);  // clamps down, takes the head
		send_request(CMD_INSERT,   8'hA5, 8'h0B, 16'hFFFF);  // duplicate after clamping
		send_request(CMD_INSERT,   8'h3C, 8'h01, 16'h0000);  // duplicate
		send_request(CMD_INSERT,   8'h11, 8'h05, 16'h0003);
		send_request(CMD_INSERT,   8'h22, 8'h05, 16'h0002);  // smaller demand goes first
		send_request(CMD_UNUSED,   8'h77, 8'h05, 16'h0002);
		send_request(CMD_ADD,      8'h5A, 8'hA5, 16'h5A5A);
		send_request(CMD_DISPATCH, 8'hA5, 8'h5A, 16'hA5A5);  // head does not fit
		load_capacity(16'h0000);
		send_request(CMD_INSERT,   8'h33, 8'h0A, 16'h0000);
		send_request(CMD_DISPATCH, 8'h00, 8'h00, 16'h0000);  // zero budget, zero demand
		load_capacity(16'hFFFF);
		send_request(CMD_ADD,      8'h00, 8'h00, 16'h0000);  // budget saturates
		send_request(CMD_DISPATCH, 8'h00, 8'h00, 16'h0000);
		repeat (3) send_request(CMD_ADD, 8'h00, 8'h00, 16'h0000);
		send_request(CMD_DISPATCH, 8'h00, 8'h00, 16'h0000);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: load_capacity(16'd40);
				1: load_capacity(16'hFFFF);
				2: load_capacity(16'h0000);
				default: load_capacity(16'($urandom_range(65535)));
			endcase
			sender_idle_pct    = (phase == 1) ? 77 : (phase == 3) ? 33 : 0;
			receiver_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 33 : 0;
			for (int n = 0; n < PHASE_ITEMS; ) begin
				send_random_request();
				if (s_tuser != CMD_UNUSED) begin
					n++;
				end
			end
		end

		wait_idle();
		$display("Sent %0d requests plus %0d unused commands over four pacing phases, %0d register loads",
			requests_sent, ignored_sent, reg_writes);
		$display("Checked %0d results: %0d served, %0d duplicates, %0d full drops, %0d none served",
			results_checked, served_count, dup_count, full_count, none_count);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("Verification passed");
		end else begin
			if (results_due != 0) begin
				$display("%0d expected results never arrived", results_due);
			end
			$display("Verification failed");
		end
		$finish;
	end

endmodule
